/* src/palint_pkg.sv */
// ----------------------------------------------------------------------------
// palint_pkg
// shared types and constants for the polyline arc length interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package palint_pkg;

  localparam int MaxPoints = 256;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = IdxW + 1;
  localparam int CoordW    = 32;
  localparam int LenW      = 48;
  localparam int PosW      = 17;
  localparam int RatioW    = 17;
  localparam int RootW     = 33;
  localparam int SumSqW    = 66;
  localparam logic [PosW-1:0] OneQ16 = 17'd65536;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FEW    = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    KIND_CLEAR,
    KIND_ADD,
    KIND_QUERY,
    KIND_BADPOS,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic [CoordW-1:0] point_z;
    logic [PosW-1:0]   position;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic [CoordW-1:0] out_z;
    status_e           status;
  } out_item_t;

  // coordinate 0 is x, 1 is y, 2 is z
  typedef logic [2:0][CoordW-1:0] point_t;

  typedef struct packed {
    kind_e           kind;
    point_t          pt;
    logic [PosW-1:0] position;
  } q_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_SQ,
    ST_ADD_GO,
    ST_ADD_RT,
    ST_Q_M1,
    ST_Q_M2,
    ST_Q_M3,
    ST_SCAN,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_DIV,
    ST_LERP,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* src/palint_ram.sv */
// ----------------------------------------------------------------------------
// palint_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module palint_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/palint_front.sv */
// ----------------------------------------------------------------------------
// palint_front
// input queue: takes items, classifies them and holds two for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module palint_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire palint_pkg::in_item_t in_item_i,
  output logic                      q_valid_o,
  output palint_pkg::q_entry_t      q_o,
  input  wire logic                 q_pop_i
);

  palint_pkg::q_entry_t ent_q [2];
  palint_pkg::q_entry_t ent_new;
  logic                 wptr_q, rptr_q;
  logic [1:0]           fill_q;
  logic                 push;

  always_comb begin
    ent_new.pt       = {in_item_i.point_z, in_item_i.point_y, in_item_i.point_x};
    ent_new.position = in_item_i.position;
    case (in_item_i.mode)
      palint_pkg::MODE_CLEAR: ent_new.kind = palint_pkg::KIND_CLEAR;
      palint_pkg::MODE_ADD:   ent_new.kind = palint_pkg::KIND_ADD;
      palint_pkg::MODE_QUERY: begin
        // range check needs no state, so it is settled here
        if (in_item_i.position > palint_pkg::OneQ16) begin
          ent_new.kind = palint_pkg::KIND_BADPOS;
        end else begin
          ent_new.kind = palint_pkg::KIND_QUERY;
        end
      end
      default: ent_new.kind = palint_pkg::KIND_NOP;
    endcase
  end

  assign in_stall_o = (fill_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (fill_q != 2'd0);
  assign q_o        = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q] <= ent_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (q_pop_i) begin
        rptr_q <= !rptr_q;
      end
      fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

`default_nettype wire

/* src/palint_sqrt.sv */
// ----------------------------------------------------------------------------
// palint_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module palint_sqrt (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [palint_pkg::SumSqW-1:0]    value_i,
  output logic                                  done_o,
  output logic      [palint_pkg::RootW-1:0]     root_o
);

  logic                              busy_q;
  logic [5:0]                        cnt_q;
  logic [palint_pkg::SumSqW-1:0]     val_q;
  logic [36:0]                       rem_q, rem_sh, trial;
  logic [palint_pkg::RootW-1:0]      root_q;
  logic                              done_q;

  assign rem_sh = {rem_q[34:0], val_q[palint_pkg::SumSqW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[palint_pkg::SumSqW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[palint_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[palint_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(palint_pkg::RootW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* src/palint_div.sv */
// ----------------------------------------------------------------------------
// palint_div
// restoring divider for the segment ratio, off * 2^16 / seg with off <= seg
// ----------------------------------------------------------------------------
`default_nettype none

module palint_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [palint_pkg::LenW-1:0]   off_i,
  input  wire logic [palint_pkg::LenW-1:0]   seg_i,
  output logic                               done_o,
  output logic      [palint_pkg::RatioW-1:0] ratio_o
);

  logic                            busy_q, first_q, done_q;
  logic [4:0]                      cnt_q;
  logic [palint_pkg::LenW-1:0]     r_q, seg_q;
  logic [palint_pkg::RatioW-1:0]   quo_q;
  logic [palint_pkg::LenW:0]       t;
  logic                            ge;

  // first step compares without a shift, giving the integer bit
  assign t  = first_q ? {1'b0, r_q} : {r_q, 1'b0};
  assign ge = (t >= {1'b0, seg_q});
  assign done_o  = done_q;
  assign ratio_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= off_i;
      seg_q <= seg_i;
      quo_q <= '0;
    end else if (busy_q) begin
      r_q   <= ge ? palint_pkg::LenW'(t - {1'b0, seg_q}) : t[palint_pkg::LenW-1:0];
      quo_q <= {quo_q[palint_pkg::RatioW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd1);
      if (start_i) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= 5'(palint_pkg::RatioW);
      end else if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* src/palint_back.sv */
// ----------------------------------------------------------------------------
// palint_back
// execution sequencer: point and length stores, add, scan and interpolate
// ----------------------------------------------------------------------------
`default_nettype none

module palint_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_valid_i,
  input  wire palint_pkg::q_entry_t  q_i,
  output logic                       q_pop_o,
  output logic                       res_valid_o,
  output palint_pkg::out_item_t      res_o,
  input  wire logic                  res_stall_i
);

  localparam int LW = palint_pkg::LenW;
  localparam int CW = palint_pkg::CoordW;

  palint_pkg::state_e    state_q, state_d;
  logic [palint_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [LW-1:0]         total_q, total_d;
  palint_pkg::q_entry_t  ent_q, ent_d;
  logic [2:0][CW:0]      dif_q, dif_d;
  logic [1:0]            c_q, c_d;
  logic [palint_pkg::SumSqW-1:0] prod_q, prod_d, acc_q, acc_d;
  logic [CW:0]           dsel;
  logic [48:0]           plo_q, plo_d;
  logic [32:0]           phi_q, phi_d;
  logic [64:0]           tsum;
  logic [LW-1:0]         target_q, target_d, lprev_q, lprev_d;
  logic [LW-1:0]         l0_q, l0_d, l1_q, l1_d;
  logic [palint_pkg::CntW-1:0] ia_q, ia_d, n_q, n_d;
  logic                  pend_q, pend_d;
  palint_pkg::point_t    p0_q, p0_d, p1_q, p1_d;
  logic signed [50:0]    lprod_q, lprod_d, ladj, lq;
  logic signed [CW:0]    ldiff;
  logic [CW-1:0]         lout;
  palint_pkg::out_item_t res_q, res_d;

  logic                          pt_we, len_we;
  logic [palint_pkg::IdxW-1:0]   pt_waddr, pt_raddr, len_raddr;
  palint_pkg::point_t            pt_rdata;
  logic [LW-1:0]                 len_wdata, len_rdata;
  logic                          sq_start, sq_done, dv_start, dv_done;
  logic [palint_pkg::RootW-1:0]  root;
  logic [LW:0]                   lsum;
  logic [LW-1:0]                 seg, off_raw, off;
  logic [palint_pkg::RatioW-1:0] ratio;

  palint_ram #(.Width(3 * CW), .Depth(palint_pkg::MaxPoints)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (ent_d.pt),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  palint_ram #(.Width(LW), .Depth(palint_pkg::MaxPoints)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (pt_waddr),
    .wdata_i (len_wdata),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  palint_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (acc_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  palint_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .off_i   (off),
    .seg_i   (seg),
    .done_o  (dv_done),
    .ratio_o (ratio)
  );

  assign lsum    = {1'b0, total_q} + {{(LW + 1 - palint_pkg::RootW){1'b0}}, root};
  assign tsum    = {phi_q, 32'd0} + {16'd0, plo_q};
  assign seg     = l1_q - l0_q;
  assign off_raw = target_q - l0_q;
  assign off     = (off_raw > seg) ? seg : off_raw;
  assign ladj    = lprod_q + (lprod_q[50] ? 51'sd65535 : 51'sd0);
  assign lq      = ladj >>> 16;

  always_comb begin
    case (c_q)
      2'd0:    dsel = dif_q[0];
      2'd1:    dsel = dif_q[1];
      2'd2:    dsel = dif_q[2];
      default: dsel = '0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    total_d   = total_q;
    ent_d     = ent_q;
    dif_d     = dif_q;
    c_d       = c_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    plo_d     = plo_q;
    phi_d     = phi_q;
    target_d  = target_q;
    lprev_d   = lprev_q;
    l0_d      = l0_q;
    l1_d      = l1_q;
    ia_d      = ia_q;
    n_d       = n_q;
    pend_d    = pend_q;
    p0_d      = p0_q;
    p1_d      = p1_q;
    lprod_d   = lprod_q;
    res_d     = res_q;
    q_pop_o   = 1'b0;
    pt_we     = 1'b0;
    len_we    = 1'b0;
    pt_waddr  = cnt_q[palint_pkg::IdxW-1:0];
    len_wdata = total_q;
    pt_raddr  = palint_pkg::IdxW'(cnt_q - palint_pkg::CntW'(1));
    len_raddr = ia_q[palint_pkg::IdxW-1:0];
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    ldiff     = '0;
    lout      = '0;

    case (state_q)
      palint_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ent_d   = q_i;
          res_d   = '0;
          state_d = palint_pkg::ST_DONE;
          case (q_i.kind)
            palint_pkg::KIND_CLEAR: begin
              cnt_d   = '0;
              total_d = '0;
            end
            palint_pkg::KIND_BADPOS: res_d.status = palint_pkg::STAT_BADPOS;
            palint_pkg::KIND_ADD: begin
              if (cnt_q == palint_pkg::CntW'(palint_pkg::MaxPoints)) begin
                res_d.status = palint_pkg::STAT_FULL;
              end else if (cnt_q == '0) begin
                // first point starts the length at zero
                pt_we     = 1'b1;
                len_we    = 1'b1;
                len_wdata = '0;
                total_d   = '0;
                cnt_d     = palint_pkg::CntW'(1);
              end else begin
                state_d = palint_pkg::ST_ADD_RD;
              end
            end
            palint_pkg::KIND_QUERY: begin
              if (cnt_q < palint_pkg::CntW'(2)) begin
                res_d.status = palint_pkg::STAT_FEW;
              end else begin
                state_d = palint_pkg::ST_Q_M1;
              end
            end
            default: ;
          endcase
        end
      end

      palint_pkg::ST_ADD_RD: begin
        for (int i = 0; i < 3; i++) begin
          ldiff = $signed({ent_q.pt[i][CW-1], ent_q.pt[i]})
                - $signed({pt_rdata[i][CW-1], pt_rdata[i]});
          dif_d[i] = ldiff[CW] ? (CW + 1)'(-ldiff) : ldiff;
        end
        c_d     = '0;
        acc_d   = '0;
        prod_d  = '0;
        state_d = palint_pkg::ST_ADD_SQ;
      end

      palint_pkg::ST_ADD_SQ: begin
        prod_d = dsel * dsel;
        acc_d  = acc_q + prod_q;
        c_d    = c_q + 2'd1;
        if (c_q == 2'd3) begin
          state_d = palint_pkg::ST_ADD_GO;
        end
      end

      palint_pkg::ST_ADD_GO: begin
        sq_start = 1'b1;
        state_d  = palint_pkg::ST_ADD_RT;
      end

      palint_pkg::ST_ADD_RT: begin
        if (sq_done) begin
          // running length saturates at the top of the q32.16 range
          total_d   = lsum[LW] ? {LW{1'b1}} : lsum[LW-1:0];
          len_wdata = total_d;
          pt_we     = 1'b1;
          len_we    = 1'b1;
          cnt_d     = cnt_q + palint_pkg::CntW'(1);
          state_d   = palint_pkg::ST_DONE;
        end
      end

      palint_pkg::ST_Q_M1: begin
        plo_d   = ent_q.position * total_q[31:0];
        state_d = palint_pkg::ST_Q_M2;
      end

      palint_pkg::ST_Q_M2: begin
        phi_d   = ent_q.position * total_q[LW-1:32];
        state_d = palint_pkg::ST_Q_M3;
      end

      palint_pkg::ST_Q_M3: begin
        target_d = tsum[63:16];
        ia_d     = palint_pkg::CntW'(1);
        n_d      = palint_pkg::CntW'(1);
        lprev_d  = '0;
        pend_d   = 1'b0;
        state_d  = palint_pkg::ST_SCAN;
      end

      palint_pkg::ST_SCAN: begin
        // one length read issued per cycle, checked in the cycle after
        ia_d   = ia_q + palint_pkg::CntW'(1);
        pend_d = 1'b1;
        if (pend_q) begin
          if (len_rdata >= target_q || n_q == cnt_q - palint_pkg::CntW'(1)) begin
            l0_d    = lprev_q;
            l1_d    = len_rdata;
            state_d = palint_pkg::ST_P0;
          end else begin
            lprev_d = len_rdata;
            n_d     = n_q + palint_pkg::CntW'(1);
          end
        end
      end

      palint_pkg::ST_P0: begin
        pt_raddr = palint_pkg::IdxW'(n_q - palint_pkg::CntW'(1));
        state_d  = palint_pkg::ST_P1;
      end

      palint_pkg::ST_P1: begin
        pt_raddr = n_q[palint_pkg::IdxW-1:0];
        p0_d     = pt_rdata;
        state_d  = palint_pkg::ST_P2;
      end

      palint_pkg::ST_P2: begin
        p1_d = pt_rdata;
        if (seg == '0 || target_q <= l0_q) begin
          // zero-length segment or target on its start
          res_d.out_x = p0_q[0];
          res_d.out_y = p0_q[1];
          res_d.out_z = p0_q[2];
          state_d     = palint_pkg::ST_DONE;
        end else begin
          dv_start = 1'b1;
          state_d  = palint_pkg::ST_DIV;
        end
      end

      palint_pkg::ST_DIV: begin
        if (dv_done) begin
          c_d     = '0;
          state_d = palint_pkg::ST_LERP;
        end
      end

      palint_pkg::ST_LERP: begin
        if (c_q != 2'd3) begin
          ldiff   = $signed({p1_q[c_q][CW-1], p1_q[c_q]})
                  - $signed({p0_q[c_q][CW-1], p0_q[c_q]});
          lprod_d = ldiff * $signed({1'b0, ratio});
        end
        if (c_q != 2'd0) begin
          lout = p0_q[c_q - 2'd1] + lq[CW-1:0];
          case (c_q)
            2'd1:    res_d.out_x = lout;
            2'd2:    res_d.out_y = lout;
            default: res_d.out_z = lout;
          endcase
        end
        c_d = c_q + 2'd1;
        if (c_q == 2'd3) begin
          state_d = palint_pkg::ST_DONE;
        end
      end

      palint_pkg::ST_DONE: begin
        if (!res_stall_i) begin
          state_d = palint_pkg::ST_IDLE;
        end
      end

      default: state_d = palint_pkg::ST_IDLE;
    endcase
  end

  assign res_valid_o = (state_q == palint_pkg::ST_DONE);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= palint_pkg::ST_IDLE;
      cnt_q   <= '0;
      total_q <= '0;
      pend_q  <= 1'b0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      pend_q  <= pend_d;
      c_q     <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q    <= ent_d;
    dif_q    <= dif_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    plo_q    <= plo_d;
    phi_q    <= phi_d;
    target_q <= target_d;
    lprev_q  <= lprev_d;
    l0_q     <= l0_d;
    l1_q     <= l1_d;
    ia_q     <= ia_d;
    n_q      <= n_d;
    p0_q     <= p0_d;
    p1_q     <= p1_d;
    lprod_q  <= lprod_d;
    res_q    <= res_d;
  end

endmodule

`default_nettype wire

/* src/polyline_arc_length_interpolator_top.sv */
// ----------------------------------------------------------------------------
// polyline_arc_length_interpolator_top
// stores up to 256 3-d points with running arc length and answers
// normalized-position queries by linear interpolation on the polyline
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------
//   in      | input     | in_valid_i / in_stall_o  | in_item_i  (in_item_t)
//   out     | output    | out_valid_o / out_stall_i| out_item_o (out_item_t)
//
// - clear, bad position, too few points, full store: result straight from idle
// - add: the first point is stored at once; later points wait on the 33-step root unit
// - query: a linear scan of the length store finds the segment of the target, then
//   the 17-step ratio divider runs unless the segment is empty or the target is on its start
// - two-entry input queue keeps taking items, until it holds two, while a result waits on stall
// - reset clears the point count and total length; the stores need no clear
//
`default_nettype none

module polyline_arc_length_interpolator_top (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire palint_pkg::in_item_t  in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output palint_pkg::out_item_t      out_item_o
);

  // queue between the classifying front and the executing back
  palint_pkg::q_entry_t q_ent;
  logic                 q_valid;
  logic                 q_pop;

  palint_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_o        (q_ent),
    .q_pop_i    (q_pop)
  );

  // the back end holds its result register until the item is taken
  palint_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_i         (q_ent),
    .q_pop_o     (q_pop),
    .res_valid_o (out_valid_o),
    .res_o       (out_item_o),
    .res_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

/* src/palint_checker.sv */
// ----------------------------------------------------------------------------
// palint_checker
// port-level checks for the polyline interpolator
// ----------------------------------------------------------------------------
`default_nettype none

module palint_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire palint_pkg::out_item_t out_item_o
);

  // stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped or changed under stall");

  // a failed request always carries a zero point
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != palint_pkg::STAT_OK |->
      out_item_o.out_x == '0 && out_item_o.out_y == '0 && out_item_o.out_z == '0)
    else $error("nonzero point with error status");

  // the back end passes through idle between results
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("back-to-back results");

  // with no item offered the queue cannot fill, so stall stays low
  a_stall_after_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && !in_valid_i |=> !in_stall_o)
    else $error("queue filled with no item taken");

endmodule

bind polyline_arc_length_interpolator_top palint_checker u_palint_checker (.*);

`default_nettype wire
